>>> src/phs_pkg.sv
// ----------------------------------------------------------------------------
// phs_pkg
// Shared widths, command and status codes, and the multiplier handshake types
// of the prefix-hash engine.
// ----------------------------------------------------------------------------
package phs_pkg;

  localparam int HASH_W   = 30;
  localparam int CMD_W    = 2;
  localparam int LETTER_W = 5;
  localparam int INDEX_W  = 12;
  localparam int BORDER_W = 13;
  localparam int STATUS_W = 2;

  // Bits of the multiplier consumed per cycle by the serial modular multiplier.
  localparam int DIGIT_W = 2;

  localparam int PHS_MAX_LEN = 4096;

  localparam logic [HASH_W-1:0] PHS_MOD       = HASH_W'(1000000007);
  localparam logic [HASH_W-1:0] PHS_BASE_INIT = HASH_W'(33);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_SUBSTR = 2'd1,
    CMD_BORDER = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] product;
  } mul_rsp_t;

endpackage

>>> src/phs_req_if.sv
// ----------------------------------------------------------------------------
// phs_req_if
// Command channel of the prefix-hash engine: valid/ready and one command.
// ----------------------------------------------------------------------------
interface phs_req_if;
  import phs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [LETTER_W-1:0] letter_index;
  logic [INDEX_W-1:0]  left_index;
  logic [INDEX_W-1:0]  right_index;
  logic [BORDER_W-1:0] border_length;

  modport source (
    output valid, cmd, letter_index, left_index, right_index, border_length,
    input  ready
  );

  modport sink (
    input  valid, cmd, letter_index, left_index, right_index, border_length,
    output ready
  );

endinterface

>>> src/phs_rsp_if.sv
// ----------------------------------------------------------------------------
// phs_rsp_if
// Result channel of the prefix-hash engine: valid/ready and one result.
// ----------------------------------------------------------------------------
interface phs_rsp_if;
  import phs_pkg::*;

  logic                valid;
  logic                ready;
  logic [HASH_W-1:0]   hash_value;
  logic                border_equal;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, hash_value, border_equal, status,
    input  ready
  );

  modport sink (
    input  valid, hash_value, border_equal, status,
    output ready
  );

endinterface

>>> src/phs_ram.sv
// ----------------------------------------------------------------------------
// phs_ram
// Simple dual-port table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module phs_ram #(
  parameter int DEPTH = phs_pkg::PHS_MAX_LEN,
  parameter int AW    = $clog2(phs_pkg::PHS_MAX_LEN)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [phs_pkg::HASH_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [phs_pkg::HASH_W-1:0] rdata
);
  import phs_pkg::*;

  logic [HASH_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read data holds until the next read, so a value can be used late.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/phs_mulmod.sv
// ----------------------------------------------------------------------------
// phs_mulmod
// Serial modular multiplier: a * b mod 1000000007, two multiplier bits a cycle.
// ----------------------------------------------------------------------------
module phs_mulmod (
  input  logic              clk,
  input  logic              rst,
  input  phs_pkg::mul_req_t mreq,
  output phs_pkg::mul_rsp_t mrsp
);
  import phs_pkg::*;

  localparam int STEPS = HASH_W / DIGIT_W;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [HASH_W+1:0] MOD_X1 = (HASH_W+2)'(PHS_MOD);
  localparam logic [HASH_W+1:0] MOD_X2 = (HASH_W+2)'({PHS_MOD, 1'b0});

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [HASH_W-1:0] acc;
  logic [HASH_W-1:0] mcand;
  logic [HASH_W-1:0] mplier;
  logic [HASH_W-1:0] acc_next;

  // One bit of the shift-and-add: 2*acc + bit*a, folded back below the modulus.
  function automatic logic [HASH_W-1:0] dbl_add(
    input logic [HASH_W-1:0] acc_in,
    input logic [HASH_W-1:0] a_in,
    input logic              bit_in
  );
    logic [HASH_W+1:0] t;
    t = (HASH_W+2)'({acc_in, 1'b0}) + (HASH_W+2)'(bit_in ? a_in : '0);
    if (t >= MOD_X2) begin
      t = t - MOD_X2;
    end else if (t >= MOD_X1) begin
      t = t - MOD_X1;
    end
    return t[HASH_W-1:0];
  endfunction

  always_comb begin
    acc_next = acc;
    for (int i = 0; i < DIGIT_W; i++) begin
      acc_next = dbl_add(acc_next, mcand, mplier[HASH_W-1-i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (mreq.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.start) begin
      acc    <= '0;
      mcand  <= mreq.a;
      mplier <= mreq.b;
    end else if (busy) begin
      acc    <= acc_next;
      mplier <= mplier << DIGIT_W;
    end
  end

  assign mrsp.done    = done;
  assign mrsp.product = acc;

endmodule

>>> src/prefix_hash_substring_query.sv
// ----------------------------------------------------------------------------
// prefix_hash_substring_query
// Work per command: clear, errors, trivial border tests and an append to an
//   empty store need no product; a substring from position 0 needs only a
//   table read; other substrings and border tests take one modular product
//   each, and other appends take two.
// One command at a time: a new one is taken only after the last result has
//   gone to the output register; the multiplier takes two bits a cycle.
// Reset: stored length 0, hash base 33; the tables are not cleared.
// ----------------------------------------------------------------------------
module prefix_hash_substring_query #(
  parameter int MAX_LEN = phs_pkg::PHS_MAX_LEN
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [phs_pkg::HASH_W-1:0] cfg_write_data,
  phs_req_if.sink                    req,
  phs_rsp_if.source                  rsp
);
  import phs_pkg::*;

  // Table address width, stored-length width, and the common width in which
  // the command fields are compared with the stored length.
  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = (LW > BORDER_W) ? LW : BORDER_W;
  localparam logic [CW-1:0] MAX_LEN_C = CW'(MAX_LEN);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_CMP   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [LW-1:0]     length;
  logic [HASH_W-1:0] hash_base;
  logic [HASH_W-1:0] base_mod;

  // Command being worked on.
  cmd_t                cmd_q;
  logic [LETTER_W-1:0] letter_q;
  logic                low_zero;
  logic                pass;
  logic [AW-1:0]       second_addr;
  logic [AW-1:0]       cmp_addr;
  logic [HASH_W-1:0]   acc;

  // Result being built, then the output register.
  logic [HASH_W-1:0] hv;
  logic              eq;
  status_t           st;
  logic              rsp_valid;
  logic [HASH_W-1:0] rsp_hash;
  logic              rsp_eq;
  status_t           rsp_status;
  logic              out_free;

  // Table ports. Both tables are written together at the same address.
  logic              h_re, p_re, mem_we;
  logic [AW-1:0]     h_raddr, p_raddr, wr_addr;
  logic [HASH_W-1:0] h_rdata, p_rdata, h_wdata, p_wdata;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // Command fields widened for the range checks, and the derived addresses.
  logic [CW-1:0] left_c, right_c, k_c, n_c;
  logic [CW-1:0] n_m1, left_m1, span, nk_m1, k_m1;

  function automatic logic [HASH_W-1:0] add_letter(
    input logic [HASH_W-1:0]   a,
    input logic [LETTER_W-1:0] l
  );
    logic [HASH_W:0] s;
    s = (HASH_W+1)'(a) + (HASH_W+1)'(l);
    if (s >= (HASH_W+1)'(PHS_MOD)) begin
      s = s - (HASH_W+1)'(PHS_MOD);
    end
    return s[HASH_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] sub_mod(
    input logic [HASH_W-1:0] a,
    input logic [HASH_W-1:0] b
  );
    logic [HASH_W:0] s;
    if (a >= b) begin
      s = (HASH_W+1)'(a) - (HASH_W+1)'(b);
    end else begin
      s = (HASH_W+1)'(a) + (HASH_W+1)'(PHS_MOD) - (HASH_W+1)'(b);
    end
    return s[HASH_W-1:0];
  endfunction

  // The base register can hold values up to 2^30-1; one subtraction brings
  // it below the modulus.
  assign base_mod = (hash_base >= PHS_MOD) ? (hash_base - PHS_MOD) : hash_base;

  assign left_c  = CW'(req.left_index);
  assign right_c = CW'(req.right_index);
  assign k_c     = CW'(req.border_length);
  assign n_c     = CW'(length);
  assign n_m1    = n_c - CW'(1);
  assign left_m1 = left_c - CW'(1);
  assign span    = right_c - left_c + CW'(1);
  assign nk_m1   = n_c - k_c - CW'(1);
  assign k_m1    = k_c - CW'(1);

  assign out_free = !rsp_valid || rsp.ready;
  assign wr_addr  = length[AW-1:0];

  // Sequencer. A substring of positions lo..hi is H[hi] - H[lo-1]*P[hi-lo+1];
  // the product is formed first while H[hi] is read into the table's output
  // register, where it waits until the product is done. A border test of
  // length k compares H[k-1] with the hash of the last k positions, and is
  // trivially equal for k zero or k equal to the stored length. An append
  // forms H[n-1]*B and then P[n-1]*B on the same multiplier.
  always_comb begin
    state_next    = state;
    h_re          = 1'b0;
    p_re          = 1'b0;
    h_raddr       = '0;
    p_raddr       = '0;
    mem_we        = 1'b0;
    h_wdata       = '0;
    p_wdata       = '0;
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_FIN;
          case (cmd_t'(req.cmd))
            CMD_APPEND: begin
              if (n_c < MAX_LEN_C) begin
                if (length == '0) begin
                  mem_we  = 1'b1;
                  h_wdata = HASH_W'(req.letter_index);
                  p_wdata = HASH_W'(1);
                end else begin
                  h_re       = 1'b1;
                  p_re       = 1'b1;
                  h_raddr    = n_m1[AW-1:0];
                  p_raddr    = n_m1[AW-1:0];
                  state_next = ST_FETCH;
                end
              end
            end
            CMD_SUBSTR: begin
              if (left_c <= right_c && right_c < n_c) begin
                h_re = 1'b1;
                if (req.left_index == '0) begin
                  h_raddr = right_c[AW-1:0];
                end else begin
                  h_raddr = left_m1[AW-1:0];
                  p_re    = 1'b1;
                  p_raddr = span[AW-1:0];
                end
                state_next = ST_FETCH;
              end
            end
            CMD_BORDER: begin
              if (k_c != '0 && k_c < n_c) begin
                h_re       = 1'b1;
                p_re       = 1'b1;
                h_raddr    = nk_m1[AW-1:0];
                p_raddr    = k_c[AW-1:0];
                state_next = ST_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FETCH: begin
        if (cmd_q == CMD_APPEND) begin
          mul_req.start = 1'b1;
          mul_req.a     = h_rdata;
          mul_req.b     = base_mod;
          state_next    = ST_MUL;
        end else if (cmd_q == CMD_SUBSTR && low_zero) begin
          state_next = ST_FIN;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = h_rdata;
          mul_req.b     = p_rdata;
          h_re          = 1'b1;
          h_raddr       = second_addr;
          state_next    = ST_MUL;
        end
      end

      ST_MUL: begin
        if (mul_rsp.done) begin
          if (cmd_q == CMD_APPEND) begin
            if (!pass) begin
              // P[n-1] still sits in the power table's read register.
              mul_req.start = 1'b1;
              mul_req.a     = p_rdata;
              mul_req.b     = base_mod;
            end else begin
              mem_we     = 1'b1;
              h_wdata    = acc;
              p_wdata    = mul_rsp.product;
              state_next = ST_FIN;
            end
          end else if (cmd_q == CMD_BORDER) begin
            h_re       = 1'b1;
            h_raddr    = cmp_addr;
            state_next = ST_CMP;
          end else begin
            state_next = ST_FIN;
          end
        end
      end

      ST_CMP: begin
        state_next = ST_FIN;
      end

      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      length    <= '0;
      hash_base <= PHS_BASE_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        hash_base <= cfg_write_data;
      end
      if (state == ST_IDLE && req.valid) begin
        if (cmd_t'(req.cmd) == CMD_CLEAR) begin
          length <= '0;
        end else if (cmd_t'(req.cmd) == CMD_APPEND && length == '0) begin
          length <= LW'(1);
        end
      end
      if (state == ST_MUL && mul_rsp.done && cmd_q == CMD_APPEND && pass) begin
        length <= length + 1'b1;
      end
      if (state == ST_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          cmd_q       <= cmd_t'(req.cmd);
          letter_q    <= req.letter_index;
          low_zero    <= (req.left_index == '0);
          pass        <= 1'b0;
          second_addr <= (cmd_t'(req.cmd) == CMD_SUBSTR) ? right_c[AW-1:0]
                                                          : n_m1[AW-1:0];
          cmp_addr    <= k_m1[AW-1:0];
          hv          <= '0;
          case (cmd_t'(req.cmd))
            CMD_APPEND: begin
              eq <= 1'b0;
              st <= (n_c >= MAX_LEN_C) ? STATUS_FULL : STATUS_OK;
            end
            CMD_SUBSTR: begin
              eq <= 1'b0;
              st <= (left_c > right_c || right_c >= n_c) ? STATUS_RANGE : STATUS_OK;
            end
            CMD_BORDER: begin
              // Empty and whole-string borders match without any table read.
              eq <= (k_c == '0 || k_c == n_c);
              st <= (k_c > n_c) ? STATUS_RANGE : STATUS_OK;
            end
            default: begin
              eq <= 1'b0;
              st <= STATUS_OK;
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (cmd_q == CMD_SUBSTR && low_zero) begin
          hv <= h_rdata;
        end
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          if (cmd_q == CMD_APPEND) begin
            if (!pass) begin
              acc  <= add_letter(mul_rsp.product, letter_q);
              pass <= 1'b1;
            end
          end else if (cmd_q == CMD_BORDER) begin
            acc <= sub_mod(h_rdata, mul_rsp.product);
          end else begin
            hv <= sub_mod(h_rdata, mul_rsp.product);
          end
        end
      end
      ST_CMP: begin
        eq <= (acc == h_rdata);
      end
      ST_FIN: begin
        if (out_free) begin
          rsp_hash   <= hv;
          rsp_eq     <= eq;
          rsp_status <= st;
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.hash_value   = rsp_hash;
  assign rsp.border_equal = rsp_eq;
  assign rsp.status       = rsp_status;

  phs_ram #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  phs_ram #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_power_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  phs_mulmod u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .mreq (mul_req),
    .mrsp (mul_rsp)
  );

  // A transaction on the command channel always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != ST_IDLE)
    else $error("command accepted but sequencer stayed idle");

  // The multiplier only finishes while the sequencer is waiting for it.
  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> state == ST_MUL)
    else $error("multiplier finished outside the multiply state");

  // A clear empties the store by the next cycle.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.cmd == CMD_CLEAR |=> length == '0)
    else $error("clear did not reset the stored length");

  // Results are fully reduced, and errors carry no hash.
  a_hash_reduced: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.hash_value < PHS_MOD &&
                  (rsp.status == STATUS_OK || rsp.hash_value == '0))
    else $error("result hash out of range");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the prefix-hash engine. Commands are fed from a
// queue through the request channel while a cycle-accurate-free predictor
// tracks the prefix and power tables. Every result is checked field by field
// against the predicted one, in order, across several hash bases.
// ----------------------------------------------------------------------------
module testbench;
  import phs_pkg::*;

  // About 550 commands, each at most an append plus the worst sender gap and
  // receiver stall, need far fewer cycles than this limit.
  localparam int CYCLE_LIMIT  = 200000;
  // Longest block latency (an append) plus some margin.
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 50;
  localparam int MAX_MISMATCH_PRINTS = 10;

  // One command as the sender sees it. The drain flag makes the sender wait
  // until every earlier result has come back before it offers the command.
  typedef struct packed {
    logic                drain_first;
    cmd_t                op;
    logic [LETTER_W-1:0] letter;
    logic [INDEX_W-1:0]  lo_pos;
    logic [INDEX_W-1:0]  hi_pos;
    logic [BORDER_W-1:0] border_len;
  } hash_cmd_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic              border_equal;
    status_t           status;
  } hash_result_t;

  logic                clk;
  logic                rst;
  logic                cfg_write_en;
  logic [HASH_W-1:0]   cfg_write_data;

  phs_req_if cmd_bus ();
  phs_rsp_if res_bus ();

  prefix_hash_substring_query u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req            (cmd_bus),
    .rsp            (res_bus)
  );

  // Commands waiting to be offered, and results waiting to be seen.
  hash_cmd_t    pend_q[$];
  hash_result_t hash_expect_q[$];

  hash_cmd_t    cur_cmd;
  bit           in_hand;
  bit           drain_next;
  int           send_wait;
  int           recv_wait;
  int           send_gap_max;
  int           recv_stall_max;
  int           fail_count;
  int           checked_count;
  int           cycle_count;

  // Bookkeeping for the stimulus side only: the store length that the queued
  // commands will leave behind, used to aim queries at valid ranges.
  int           gen_len;
  int           queued;

  // Predictor state. The tables hold the running prefix hash and the power
  // of the base at each position; the base is the last value written.
  logic [HASH_W-1:0] prefix_tbl [PHS_MAX_LEN];
  logic [HASH_W-1:0] power_tbl  [PHS_MAX_LEN];
  int unsigned       model_len;
  logic [HASH_W-1:0] model_base;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic logic [HASH_W-1:0] mod_mul(input logic [HASH_W-1:0] a,
                                                input logic [HASH_W-1:0] b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return HASH_W'(prod % 64'(PHS_MOD));
  endfunction

  // Hash of positions lo..hi: H[hi] - H[lo-1] * P[hi-lo+1], kept
  // non-negative by adding the modulus before the subtraction.
  function automatic logic [HASH_W-1:0] span_hash(input int unsigned lo,
                                                  input int unsigned hi);
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] sub;
    h = prefix_tbl[hi];
    if (lo != 0) begin
      sub = mod_mul(prefix_tbl[lo - 1], power_tbl[hi - lo + 1]);
      h = HASH_W'((64'(h) + 64'(PHS_MOD) - 64'(sub)) % 64'(PHS_MOD));
    end
    return h;
  endfunction

  // Applies one accepted command to the predicted state and returns the
  // result that the block must produce for it.
  function automatic hash_result_t apply_command(input hash_cmd_t c);
    hash_result_t      r;
    logic [HASH_W-1:0] b;
    int unsigned       pos;
    int unsigned       k;
    r = '0;
    r.status = STATUS_OK;
    // The register may hold values at or above the modulus.
    b = HASH_W'(64'(model_base) % 64'(PHS_MOD));
    k = c.border_len;
    case (c.op)
      CMD_APPEND: begin
        if (model_len >= PHS_MAX_LEN) begin
          r.status = STATUS_FULL;
        end else begin
          pos = model_len;
          if (pos == 0) begin
            prefix_tbl[0] = HASH_W'(c.letter);
            power_tbl[0]  = HASH_W'(1);
          end else begin
            prefix_tbl[pos] = HASH_W'((64'(mod_mul(prefix_tbl[pos - 1], b)) + 64'(c.letter))
                                      % 64'(PHS_MOD));
            power_tbl[pos]  = mod_mul(power_tbl[pos - 1], b);
          end
          model_len = pos + 1;
        end
      end
      CMD_SUBSTR: begin
        if (c.lo_pos > c.hi_pos || c.hi_pos >= model_len) begin
          r.status = STATUS_RANGE;
        end else begin
          r.hash_value = span_hash(c.lo_pos, c.hi_pos);
        end
      end
      CMD_BORDER: begin
        if (k > model_len) begin
          r.status = STATUS_RANGE;
        end else if (k == 0) begin
          // Two empty strings always match.
          r.border_equal = 1'b1;
        end else begin
          r.border_equal = (span_hash(0, k - 1) == span_hash(model_len - k, model_len - 1));
        end
      end
      CMD_CLEAR: begin
        // Only the length goes back to zero; the tables keep their contents.
        model_len = 0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued commands, holds each one until it is accepted and
  // then waits a random number of cycles before the next.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    hash_cmd_t head;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
      send_wait = 0;
      in_hand = 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        hash_expect_q.push_back(apply_command(cur_cmd));
        in_hand = 1'b0;
        send_wait = $urandom_range(0, send_gap_max);
      end
      // A command that is offered but not yet taken stays on the bus.
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          cmd_bus.valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          head = pend_q[0];
          if (!head.drain_first || hash_expect_q.size() == 0) begin
            cur_cmd = pend_q.pop_front();
            in_hand = 1'b1;
            cmd_bus.valid         <= 1'b1;
            cmd_bus.cmd           <= cur_cmd.op;
            cmd_bus.letter_index  <= cur_cmd.letter;
            cmd_bus.left_index    <= cur_cmd.lo_pos;
            cmd_bus.right_index   <= cur_cmd.hi_pos;
            cmd_bus.border_length <= cur_cmd.border_len;
          end else begin
            cmd_bus.valid <= 1'b0;
          end
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes results, stalling a random number of cycles after each,
  // and compares them with the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_MISMATCH_PRINTS) begin
      $display("[%0t] %s", $time, what);
    end
  endtask

  always @(posedge clk) begin : collect_proc
    hash_result_t want;
    if (rst) begin
      res_bus.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        checked_count++;
        if (hash_expect_q.size() == 0) begin
          log_failure($sformatf("result %0d with nothing expected: hash=%0d eq=%0b status=%0d",
                                checked_count, res_bus.hash_value, res_bus.border_equal,
                                res_bus.status));
        end else begin
          want = hash_expect_q.pop_front();
          if (res_bus.hash_value !== want.hash_value ||
              res_bus.border_equal !== want.border_equal ||
              res_bus.status !== want.status) begin
            log_failure($sformatf(
              "result %0d: expected hash=%0d eq=%0b status=%0d, got hash=%0d eq=%0b status=%0d",
              checked_count, want.hash_value, want.border_equal, want.status,
              res_bus.hash_value, res_bus.border_equal, res_bus.status));
          end
        end
        recv_wait = $urandom_range(0, recv_stall_max);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog against a hung block or a lost result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Fields that the operation does not use are random, so that every bit
  // of every field is exercised even by well-formed commands.
  function automatic hash_cmd_t blank_cmd(input cmd_t op);
    hash_cmd_t c;
    c.drain_first = 1'b0;
    c.op          = op;
    c.letter      = LETTER_W'($urandom_range(0, 31));
    c.lo_pos      = INDEX_W'($urandom);
    c.hi_pos      = INDEX_W'($urandom);
    c.border_len  = BORDER_W'($urandom);
    return c;
  endfunction

  task automatic queue_cmd(input hash_cmd_t c);
    c.drain_first = drain_next;
    drain_next = 1'b0;
    pend_q.push_back(c);
    queued++;
    if (c.op == CMD_APPEND && gen_len < PHS_MAX_LEN) gen_len++;
    if (c.op == CMD_CLEAR) gen_len = 0;
  endtask

  task automatic send_append(input int letter);
    hash_cmd_t c;
    c = blank_cmd(CMD_APPEND);
    c.letter = LETTER_W'(letter);
    queue_cmd(c);
  endtask

  task automatic send_substr(input int lo, input int hi);
    hash_cmd_t c;
    c = blank_cmd(CMD_SUBSTR);
    c.lo_pos = INDEX_W'(lo);
    c.hi_pos = INDEX_W'(hi);
    queue_cmd(c);
  endtask

  task automatic send_border(input int k);
    hash_cmd_t c;
    c = blank_cmd(CMD_BORDER);
    c.border_len = BORDER_W'(k);
    queue_cmd(c);
  endtask

  task automatic send_clear();
    queue_cmd(blank_cmd(CMD_CLEAR));
  endtask

  // Builds a periodic string (often from an empty store) and then queries it.
  // Periodicity makes border tests at len - m*period match, so both outcomes
  // of the border comparison show up regularly.
  task automatic periodic_run();
    logic [LETTER_W-1:0] motif [6];
    int period;
    int n;
    int nq;
    int hi;
    if (gen_len > 300 || $urandom_range(0, 1) == 1) send_clear();
    period = $urandom_range(1, 6);
    for (int i = 0; i < period; i++) begin
      // Letter values past 'z' are legal and get added as they are.
      motif[i] = ($urandom_range(0, 9) == 0) ? LETTER_W'($urandom_range(26, 31))
                                             : LETTER_W'($urandom_range(0, 25));
    end
    n = $urandom_range(4, 40);
    for (int i = 0; i < n && gen_len < PHS_MAX_LEN; i++) send_append(motif[i % period]);
    nq = $urandom_range(4, 10);
    for (int q = 0; q < nq; q++) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          hi = $urandom_range(0, gen_len - 1);
          send_substr($urandom_range(0, hi), hi);
        end
        2: send_border(gen_len - period * $urandom_range(1, gen_len / period));
        default: send_border($urandom_range(0, gen_len));
      endcase
    end
  endtask

  // Fully random commands; most queries in here fall out of range.
  task automatic noise_run();
    int n;
    n = $urandom_range(5, 15);
    for (int i = 0; i < n; i++) queue_cmd(blank_cmd(cmd_t'($urandom_range(0, 3))));
  endtask

  // Queries just past the valid edges.
  task automatic edge_errors();
    int hi;
    if (gen_len < PHS_MAX_LEN) send_substr($urandom_range(0, gen_len), gen_len);
    if (gen_len >= 2) begin
      hi = $urandom_range(0, gen_len - 2);
      send_substr($urandom_range(hi + 1, gen_len - 1), hi);
    end else begin
      send_substr(1, 0);
    end
    send_border($urandom_range(gen_len + 1, gen_len + 3));
  endtask

  task automatic write_base(input logic [HASH_W-1:0] value);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    model_base = value;
  endtask

  // Returns once nothing is queued, offered or expected, plus the latency
  // of the slowest command so the block is surely idle.
  task automatic wait_idle();
    while (pend_q.size() != 0 || in_hand || hash_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int target;
    int hi;

    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.cmd           = CMD_APPEND;
    cmd_bus.letter_index  = '0;
    cmd_bus.left_index    = '0;
    cmd_bus.right_index   = '0;
    cmd_bus.border_length = '0;
    res_bus.ready  = 1'b0;
    model_base     = PHS_BASE_INIT;
    model_len      = 0;
    gen_len        = 0;
    queued         = 0;
    drain_next     = 1'b0;
    fail_count     = 0;
    checked_count  = 0;
    cycle_count    = 0;
    send_gap_max   = 8;
    recv_stall_max = 8;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset base. Queries on an empty store first: the empty
    // border matches, everything else is out of range.
    send_border(0);
    send_substr(0, 0);
    send_border(1);
    // A string of period three, with the smallest letter, the last letter
    // and the largest value the field can carry.
    send_append(0);
    send_append(25);
    send_append(31);
    send_append(0);
    send_append(25);
    send_append(31);
    send_substr(0, 5);
    send_substr(3, 5);
    send_substr(0, 2);
    send_substr(5, 5);
    send_substr(4, 2);
    send_substr(0, 6);
    // This one waits until the block has drained before it is offered.
    drain_next = 1'b1;
    send_substr(4095, 4095);
    send_border(3);
    send_border(6);
    send_border(7);
    send_border(2);
    send_border(0);
    send_border(8191);
    send_clear();
    send_substr(0, 0);
    send_append(1);
    wait_idle();

    // Random phases, each under its own base and a chosen idling pattern.
    // Bases at or above the modulus, and the degenerate bases zero and one,
    // are in the mix as well as the largest valid base.
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase)
        0: begin write_base(HASH_W'(2));             send_gap_max = 8; recv_stall_max = 8; end
        1: begin write_base({HASH_W{1'b1}});         send_gap_max = 0; recv_stall_max = 8; end
        2: begin write_base(PHS_MOD);                send_gap_max = 8; recv_stall_max = 0; end
        3: begin write_base('0);                     send_gap_max = 8; recv_stall_max = 8; end
        4: begin write_base(HASH_W'(1));             send_gap_max = 3; recv_stall_max = 3; end
        5: begin write_base(PHS_MOD - HASH_W'(1));   send_gap_max = 0; recv_stall_max = 0; end
        6: begin write_base(PHS_BASE_INIT);          send_gap_max = 4; recv_stall_max = 8; end
        default: begin
          write_base(HASH_W'($urandom));
          send_gap_max = 8;
          recv_stall_max = 8;
        end
      endcase
      target = queued + PHASE_ITEMS;
      while (queued < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: periodic_run();
          6, 7: noise_run();
          8: edge_errors();
          default: begin
            // A valid query (or an append on an empty store) that is held
            // back until all earlier results are in.
            drain_next = 1'b1;
            if (gen_len == 0) begin
              send_append($urandom_range(0, 25));
            end else begin
              hi = $urandom_range(0, gen_len - 1);
              send_substr($urandom_range(0, hi), hi);
            end
          end
        endcase
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
